// ===== sv/ils_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ils_pkg;

  // default width of the scanned value
  localparam int VALUE_BITS_DEF = 31;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // digit value of a byte that is no hex digit
  localparam logic [4:0] DIGIT_NONE = 5'd16;

  // character codes
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_LO_X   = 8'h78;
  localparam logic [7:0] CH_UP_X   = 8'h58;

  // classified item as it travels from front to back
  typedef struct packed {
    logic       term;
    logic       is_zero;
    logic       is_x;
    logic [4:0] digit;
  } cls_item_t;

endpackage

`default_nettype wire

// ===== sv/int_literal_scanner_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Integer literal scanner. Send the characters of one literal, one byte per
// item, then an item with terminator set; that item alone yields a result with
// a status (scanned, overflow, digit out of range, empty) and the value, which
// is zero unless the status is scanned. The base follows C rules: 0x or 0X is
// hex, another leading 0 is octal, anything else decimal, a lone 0 is zero.
// The block takes one item per clock while the queue has room: a front stage
// classifies each byte into a two-entry queue, and the back stage does one
// shift-and-add accumulate step per cycle. Results are registered, and a held
// result blocks the back stage only when the next terminator arrives.

module int_literal_scanner_top import ils_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            char_code,
  input  wire logic                  terminator,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 status,
  output logic [VALUE_BITS-1:0]      value
);

  cls_item_t front_item;
  cls_item_t head_item;
  logic      q_full;
  logic      head_valid;
  logic      q_pop;

  assign in_stall = q_full;

  // classify incoming bytes
  ils_front u_front (
    .char_code  (char_code),
    .terminator (terminator),
    .item       (front_item)
  );

  // decoupling queue
  ils_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid),
    .push_item  (front_item),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (q_pop)
  );

  // accumulate and report
  ils_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (head_valid),
    .q_item    (head_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .value     (value)
  );

endmodule

`default_nettype wire

// ===== sv/ils_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ils_front import ils_pkg::*; (
  input  wire logic [7:0] char_code,
  input  wire logic       terminator,
  output cls_item_t       item
);

  logic [7:0] ofs;
  logic [4:0] digit;

  // digit value, either case for hex letters
  always_comb begin
    ofs   = 8'd0;
    digit = DIGIT_NONE;
    if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
      ofs   = char_code - CH_ZERO;
      digit = ofs[4:0];
    end else if (char_code >= CH_LO_A && char_code <= CH_LO_F) begin
      ofs   = char_code - CH_LO_A + 8'd10;
      digit = ofs[4:0];
    end else if (char_code >= CH_UP_A && char_code <= CH_UP_F) begin
      ofs   = char_code - CH_UP_A + 8'd10;
      digit = ofs[4:0];
    end
  end

  // classification flags
  always_comb begin
    item.term    = terminator;
    item.is_zero = (char_code == CH_ZERO);
    item.is_x    = (char_code == CH_LO_X) || (char_code == CH_UP_X);
    item.digit   = digit;
  end

endmodule

`default_nettype wire

// ===== sv/ils_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ils_queue import ils_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire cls_item_t push_item,
  output logic           full,
  output logic           head_valid,
  output cls_item_t      head_item,
  input  wire logic      pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  cls_item_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/ils_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ils_back import ils_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_valid,
  input  wire cls_item_t             q_item,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 status,
  output logic [VALUE_BITS-1:0]      value
);

  localparam int SUM_W = VALUE_BITS + 5;

  typedef enum logic [1:0] {
    PH_START,
    PH_ZERO,
    PH_HEXPFX,
    PH_DIGITS
  } phase_t;

  typedef enum logic [1:0] {
    RX_DEC,
    RX_OCT,
    RX_HEX
  } radix_t;

  phase_t                phase;
  radix_t                radix_sel;
  logic [VALUE_BITS-1:0] accum;
  logic                  digit_seen;
  logic [1:0]            error_code;
  logic                  error_flag;

  radix_t                eff_radix;
  logic [SUM_W-1:0]      acc_ext;
  logic [SUM_W-1:0]      prod;
  logic [SUM_W-1:0]      sum;
  logic                  ovf;
  logic                  bad_digit;
  logic                  take;
  logic [1:0]            res_status;
  logic [VALUE_BITS-1:0] res_value;

  // a result waits in the output register only on a terminator
  assign q_pop = q_valid && (!q_item.term || !out_valid || !out_stall);

  // base in force for this character
  always_comb begin
    unique case (phase)
      PH_START: eff_radix = RX_DEC;
      PH_ZERO:  eff_radix = RX_OCT;
      default:  eff_radix = radix_sel;
    endcase
  end

  // accum * base + digit as shifts and adds
  always_comb begin
    acc_ext = SUM_W'(accum);
    unique case (eff_radix)
      RX_OCT:  prod = acc_ext << 3;
      RX_HEX:  prod = acc_ext << 4;
      default: prod = (acc_ext << 3) + (acc_ext << 1);
    endcase
    sum = prod + SUM_W'(q_item.digit);
    ovf = (sum[SUM_W-1:VALUE_BITS] != '0);
    unique case (eff_radix)
      RX_OCT:  bad_digit = (q_item.digit >= 5'd8);
      RX_HEX:  bad_digit = (q_item.digit >= 5'd16);
      default: bad_digit = (q_item.digit >= 5'd10);
    endcase
  end

  // does this character go through the digit path
  always_comb begin
    unique case (phase)
      PH_START: take = !q_item.is_zero;
      PH_ZERO:  take = !q_item.is_x;
      default:  take = 1'b1;
    endcase
  end

  // result of a terminator
  always_comb begin
    res_value = '0;
    if (phase == PH_ZERO) begin
      res_status = ST_OK;
    end else if (!digit_seen) begin
      res_status = ST_EMPTY;
    end else if (error_flag) begin
      res_status = error_code;
    end else begin
      res_status = ST_OK;
      res_value  = accum;
    end
  end

  // scan state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      radix_sel  <= RX_DEC;
      accum      <= '0;
      digit_seen <= 1'b0;
      error_code <= ST_OK;
      error_flag <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        if (q_item.term) begin
          out_valid  <= 1'b1;
          status     <= res_status;
          value      <= res_value;
          phase      <= PH_START;
          radix_sel  <= RX_DEC;
          accum      <= '0;
          digit_seen <= 1'b0;
          error_code <= ST_OK;
          error_flag <= 1'b0;
        end else begin
          unique case (phase)
            PH_START: begin
              phase <= q_item.is_zero ? PH_ZERO : PH_DIGITS;
            end
            PH_ZERO: begin
              phase     <= q_item.is_x ? PH_HEXPFX : PH_DIGITS;
              radix_sel <= q_item.is_x ? RX_HEX : RX_OCT;
            end
            default: begin
              phase <= PH_DIGITS;
            end
          endcase
          if (take) begin
            digit_seen <= 1'b1;
            if (!error_flag) begin
              if (bad_digit) begin
                error_flag <= 1'b1;
                error_code <= ST_RANGE;
              end else if (ovf) begin
                error_flag <= 1'b1;
                error_code <= ST_OVERFLOW;
              end else begin
                accum <= sum[VALUE_BITS-1:0];
              end
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/ils_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ils_checker import ils_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic [7:0]            char_code,
  input wire logic                  terminator,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [1:0]            status,
  input wire logic [VALUE_BITS-1:0] value
);

  // failed or empty scans carry a zero value
  a_err_value_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (value == '0))
    else $error("nonzero value with error status");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(value)))
    else $error("stalled result changed");

  // a stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_stall) |=>
      (in_valid && $stable(char_code) && $stable(terminator)))
    else $error("stalled input item changed");

  // reset leaves no result pending
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // reset leaves the queue empty so input is open
  a_reset_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind int_literal_scanner_top ils_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_ils_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .char_code  (char_code),
  .terminator (terminator),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .value      (value)
);

`default_nettype wire
